// File: rtl/core/mvb_pkg.sv
// Shared types and constants of the matrix-vector multiply with bias block.
package mvb_pkg;

  localparam int unsigned MaxVectorLenDef = 4096;
  localparam int unsigned MaxRowsDef      = 4096;

  localparam int unsigned ElemW   = 16;
  localparam int unsigned BiasW   = 32;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned AccW    = 48;
  localparam int unsigned ResW    = 32;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned InDataW = 48;

  localparam logic [CfgW-1:0] VectorLengthRst = 13'd16;
  localparam logic [CfgW-1:0] RowCountRst     = 13'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VECTOR_LENGTH = 4'd0,
    CFG_ROW_COUNT     = 4'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_e;

  // Per-item control traveling with a matrix element down the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_col;
    logic last_row;
  } mac_ctl_t;

endpackage

// File: rtl/core/mvb_vec_mem.sv
// Vector store: single-port synchronous memory with registered read data.
module mvb_vec_mem #(
  parameter int unsigned Depth = mvb_pkg::MaxVectorLenDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [mvb_pkg::ElemW-1:0]  wdata_i,
  output logic [mvb_pkg::ElemW-1:0]  rdata_o
);

  logic [mvb_pkg::ElemW-1:0] mem_q [Depth];
  logic [mvb_pkg::ElemW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read so a stalled pipeline keeps its operand.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mvb_mac.sv
// Multiply, accumulate, saturate and output register of the row results.
module mvb_mac #(
  parameter int unsigned RowW = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvb_pkg::mac_ctl_t                 s1_ctl_i,
  input  logic signed [mvb_pkg::ElemW-1:0]  elem_i,
  input  logic signed [mvb_pkg::ElemW-1:0]  vec_i,
  input  logic signed [mvb_pkg::BiasW-1:0]  bias_i,
  input  logic        [RowW-1:0]            row_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [mvb_pkg::ResW-1:0]   out_result_o,
  output logic        [RowW-1:0]            out_row_o,
  output logic                              out_last_o
);

  localparam int unsigned AccW  = mvb_pkg::AccW;
  localparam int unsigned ResW  = mvb_pkg::ResW;
  localparam int unsigned ProdW = mvb_pkg::ProdW;

  mvb_pkg::mac_ctl_t                s2_ctl_q;
  logic signed [mvb_pkg::ProdW-1:0] s2_prod_q;
  logic signed [mvb_pkg::BiasW-1:0] s2_bias_q;
  logic        [RowW-1:0]           s2_row_q;
  logic signed [mvb_pkg::ProdW-1:0] prod;

  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] acc_base;
  logic [ResW-1:0] sat_res;
  logic            emit;
  logic            adv;

  logic            out_valid_q;
  logic [ResW-1:0] out_result_q;
  logic [RowW-1:0] out_row_q;
  logic            out_last_q;

  assign prod = ProdW'(elem_i) * ProdW'(vec_i);

  always_comb begin
    acc_base = s2_ctl_q.first
             ? {{(AccW-mvb_pkg::BiasW){s2_bias_q[mvb_pkg::BiasW-1]}}, s2_bias_q}
             : acc_q;
    acc_d = acc_base + {{(AccW-mvb_pkg::ProdW){s2_prod_q[mvb_pkg::ProdW-1]}}, s2_prod_q};
    // Upper bits all equal to the sign means the sum fits in the result.
    if ((&acc_d[AccW-1:ResW-1]) || !(|acc_d[AccW-1:ResW-1])) begin
      sat_res = acc_d[ResW-1:0];
    end else if (acc_d[AccW-1]) begin
      sat_res = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(ResW-1){1'b1}}};
    end
  end

  assign emit = s2_ctl_q.valid && s2_ctl_q.last_col;
  // Freeze only when a finished row meets an occupied, stalled output slot.
  assign adv  = !(out_valid_q && !out_ready_i && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q    <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s2_ctl_q <= s1_ctl_i;
        if (s2_ctl_q.valid) begin
          acc_q <= acc_d;
        end
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_prod_q <= prod;
      s2_bias_q <= bias_i;
      s2_row_q  <= row_i;
    end
    if (adv && emit) begin
      out_result_q <= sat_res;
      out_row_q    <= s2_row_q;
      out_last_q   <= s2_ctl_q.last_row;
    end
  end

  assign adv_o        = adv;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_row_o    = out_row_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/core/matrix_vector_multiply_bias_top.sv
// A row's last matrix element passes the s1 and s2 registers, then the output register.
// Throughput: one item (vector load or matrix element) per cycle when not stalled;
// each item makes one access to the single-port vector store, which sets that rate.
// Output backpressure stalls input only when a finished row finds the output slot full.
// Reset clears positions, accumulator and pipeline, and sets the lengths to 16 and 4;
// vector store contents stay undefined until loaded (no clearing pass).
module matrix_vector_multiply_bias_top #(
  parameter int unsigned MAX_VECTOR_LEN = mvb_pkg::MaxVectorLenDef,
  parameter int unsigned MAX_ROWS       = mvb_pkg::MaxRowsDef,
  localparam int unsigned RowW          = $clog2(MAX_ROWS),
  localparam int unsigned OutDataW      = ((mvb_pkg::ResW + RowW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mvb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mvb_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mvb_pkg::InDataW-1:0]   s_axis_tdata,  // element[15:0], row_bias[47:16]
  input  logic                          s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDataW-1:0]           m_axis_tdata,  // row_result[31:0], row_index, zero pad
  output logic                          m_axis_tlast   // last_row
);

  localparam int unsigned AddrW    = $clog2(MAX_VECTOR_LEN);
  localparam int unsigned LenW     = $clog2(MAX_VECTOR_LEN + 1);
  localparam int unsigned RowCntW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned ElemW    = mvb_pkg::ElemW;
  localparam int unsigned BiasW    = mvb_pkg::BiasW;

  function automatic logic [31:0] clamp_bound(logic [mvb_pkg::CfgW-1:0] v,
                                              int unsigned max);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) begin
      r = 32'd1;
    end else if (r > max) begin
      r = max;
    end
    return r;
  endfunction

  logic [LenW-1:0]    len_q, len_d;
  logic [RowCntW-1:0] rows_q, rows_d;
  logic [AddrW-1:0]   load_pos_q, load_pos_d;
  logic [AddrW-1:0]   col_pos_q, col_pos_d;
  logic [RowW-1:0]    row_pos_q, row_pos_d;

  logic [AddrW-1:0]   load_eff, col_eff;
  logic [RowW-1:0]    row_eff;
  logic [LenW-1:0]    load_nxt, col_nxt;
  logic [RowCntW-1:0] row_nxt;
  logic               last_col, last_row, first_col;

  logic               accept, is_mat, adv;
  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_addr;
  logic [ElemW-1:0]   vec_rdata;

  mvb_pkg::mac_ctl_t  s1_ctl_q;
  logic [ElemW-1:0]   s1_elem_q;
  logic [BiasW-1:0]   s1_bias_q;
  logic [RowW-1:0]    s1_row_q;

  logic [mvb_pkg::ResW-1:0] out_result;
  logic [RowW-1:0]          out_row;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_mat        = (mvb_pkg::op_e'(s_axis_tuser) == mvb_pkg::OP_MATRIX);

  // Clamp register values once at write time.
  always_comb begin
    len_d  = len_q;
    rows_d = rows_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (mvb_pkg::cfg_idx_e'(cfg_index_i))
        mvb_pkg::CFG_VECTOR_LENGTH: len_d  = LenW'(clamp_bound(cfg_data_i, MAX_VECTOR_LEN));
        mvb_pkg::CFG_ROW_COUNT:     rows_d = RowCntW'(clamp_bound(cfg_data_i, MAX_ROWS));
        default: ;
      endcase
    end
  end

  // A position left at or beyond a shrunken bound acts as zero.
  always_comb begin
    load_eff  = (LenW'(load_pos_q) >= len_q) ? '0 : load_pos_q;
    col_eff   = (LenW'(col_pos_q) >= len_q) ? '0 : col_pos_q;
    row_eff   = (RowCntW'(row_pos_q) >= rows_q) ? '0 : row_pos_q;
    load_nxt  = LenW'(load_eff) + LenW'(1);
    col_nxt   = LenW'(col_eff) + LenW'(1);
    row_nxt   = RowCntW'(row_eff) + RowCntW'(1);
    last_col  = (col_nxt >= len_q);
    last_row  = (row_nxt >= rows_q);
    first_col = (col_eff == '0);

    load_pos_d = load_pos_q;
    col_pos_d  = col_pos_q;
    row_pos_d  = row_pos_q;
    if (accept && !is_mat) begin
      load_pos_d = (load_nxt >= len_q) ? '0 : AddrW'(load_nxt);
    end
    if (accept && is_mat) begin
      col_pos_d = last_col ? '0 : AddrW'(col_nxt);
      // Commit the wrapped row position so a later, larger count keeps it.
      row_pos_d = row_eff;
      if (last_col) begin
        row_pos_d = last_row ? '0 : RowW'(row_nxt);
      end
    end
  end

  assign mem_we   = accept && !is_mat;
  assign mem_re   = accept && is_mat;
  assign mem_addr = is_mat ? col_eff : load_eff;

  mvb_vec_mem #(
    .Depth (MAX_VECTOR_LEN),
    .AddrW (AddrW)
  ) u_vec_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (s_axis_tdata[ElemW-1:0]),
    .rdata_o (vec_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LenW'(clamp_bound(mvb_pkg::VectorLengthRst, MAX_VECTOR_LEN));
      rows_q     <= RowCntW'(clamp_bound(mvb_pkg::RowCountRst, MAX_ROWS));
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      s1_ctl_q   <= '0;
    end else begin
      len_q      <= len_d;
      rows_q     <= rows_d;
      load_pos_q <= load_pos_d;
      col_pos_q  <= col_pos_d;
      row_pos_q  <= row_pos_d;
      if (adv) begin
        s1_ctl_q <= '{valid:    mem_re,
                      first:    first_col,
                      last_col: last_col,
                      last_row: last_row};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_elem_q <= s_axis_tdata[ElemW-1:0];
      s1_bias_q <= s_axis_tdata[ElemW +: BiasW];
      s1_row_q  <= row_eff;
    end
  end

  mvb_mac #(
    .RowW (RowW)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_ctl_i     (s1_ctl_q),
    .elem_i       (s1_elem_q),
    .vec_i        (vec_rdata),
    .bias_i       (s1_bias_q),
    .row_i        (s1_row_q),
    .adv_o        (adv),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result),
    .out_row_o    (out_row),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'({out_row, out_result});

endmodule

// File: rtl/core/mvb_checker.sv
// Port-level assertions for the matrix-vector multiply with bias block, bound to the top.
module mvb_checker #(
  parameter int unsigned MAX_ROWS  = mvb_pkg::MaxRowsDef,
  localparam int unsigned RowW     = $clog2(MAX_ROWS),
  localparam int unsigned OutDataW = ((mvb_pkg::ResW + RowW + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  logic [RowW-1:0] idx;
  logic [RowW-1:0] prev_idx_q;
  logic            have_prev_q;
  logic            after_last_q;

  assign idx = m_axis_tdata[mvb_pkg::ResW +: RowW];

  // Track the row index of the previous result transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_idx_q   <= '0;
      have_prev_q  <= 1'b0;
      after_last_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      prev_idx_q   <= idx;
      have_prev_q  <= 1'b1;
      after_last_q <= m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_pass_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && after_last_q |-> idx == '0)
    else $error("row index not zero after last row");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && have_prev_q && !after_last_q |->
      (idx == prev_idx_q + RowW'(1)) || (idx == '0))
    else $error("row index out of sequence");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output slot");

endmodule

bind matrix_vector_multiply_bias_top mvb_checker #(
  .MAX_ROWS (MAX_ROWS)
) u_mvb_checker (.*);
